// File: src/b2bcd_pkg.sv
package b2bcd_pkg;

	localparam int VALUE_W         = 40;
	localparam int BCD_DIGITS      = 13;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int BYTE_SLOTS      = (BCD_W + 7) / 8;
	localparam int COUNT_W         = 4;
	localparam int POS_W           = 3;
	localparam int STEPS_PER_STAGE = 8;
	localparam int DAB_STAGES      = VALUE_W / STEPS_PER_STAGE;

	localparam logic [7:0] PAD_BYTE = 8'hF0;

	typedef struct packed {
		logic [VALUE_W-1:0] bin;
		logic [BCD_W-1:0]   bcd;
	} dab_t;

	// Run one stage worth of shift-add-3 steps, MSB of the binary word first.
	function automatic dab_t dab_stage(dab_t d);
		dab_t r;
		r = d;
		for (int s = 0; s < STEPS_PER_STAGE; s++) begin
			for (int i = 0; i < BCD_DIGITS; i++) begin
				if (r.bcd[4*i +: 4] >= 4'd5) begin
					r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
				end
			end
			r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
			r.bin = {r.bin[VALUE_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// Position of the highest nonzero digit, plus one; zero has no digits.
	function automatic logic [COUNT_W-1:0] count_digits(logic [BCD_W-1:0] bcd);
		logic [COUNT_W-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				cnt = COUNT_W'(i + 1);
			end
		end
		return cnt;
	endfunction

endpackage

// File: src/b2bcd_in_if.sv
interface b2bcd_in_if import b2bcd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// File: src/b2bcd_out_if.sv
interface b2bcd_out_if import b2bcd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [7:0]         byte_value;
	logic [POS_W-1:0]   byte_position;
	logic [COUNT_W-1:0] digit_count;
	logic               overflow;
	logic               last;

	modport source (output valid, output byte_value, output byte_position,
		output digit_count, output overflow, output last, input ready);
	modport sink   (input valid, input byte_value, input byte_position,
		input digit_count, input overflow, input last, output ready);
endinterface

// File: src/binary_to_packed_bcd_f_pad.sv
// Channel   Dir   Payload                                                    Transaction
// number    in    value[39:0]                                                one binary value
// digits    out   byte_value, byte_position, digit_count, overflow, last     one packed BCD byte
//
// An input value crosses five shift-add-3 stages of eight steps each, one stage that
// counts digits and checks the limits, then a byte serializer. The serializer sets the
// pace: it sends max(1, ceil(count/2)) bytes per value (one on overflow), at most six with
// the default field of six bytes, and takes no new value until the final byte is handed off.
// Reset clears every valid bit and the serializer byte index; data registers are not reset.
// The whole pipeline advances on one enable; a stall on the output freezes every stage.
module binary_to_packed_bcd_f_pad import b2bcd_pkg::*; #(
	parameter int MAX_DIGITS  = 12,
	parameter int FIELD_BYTES = 6
) (
	input logic          clk,
	input logic          arst_n,
	b2bcd_in_if.sink     number,
	b2bcd_out_if.source  digits
);

	// Shift-add-3 stages, one per group of eight input bits
	dab_t dab_s [DAB_STAGES];
	logic vld_s [DAB_STAGES];

	// Digit count and limit check
	logic [BCD_W-1:0]   bcd_s6;
	logic [COUNT_W-1:0] cnt_s6;
	logic [POS_W-1:0]   top_s6;
	logic               ovf_s6;
	logic               vld_s6;

	// Byte serializer
	logic [BYTE_SLOTS-1:0][7:0] ser_bytes_q;
	logic [COUNT_W-1:0]         ser_cnt_q;
	logic [POS_W-1:0]           ser_top_q;
	logic [POS_W-1:0]           ser_k_q;
	logic                       ser_ovf_q;
	logic                       ser_vld_q;

	logic               adv;
	logic               ser_last;
	logic               ser_pad;
	logic [COUNT_W-1:0] cnt_d;
	logic [POS_W-1:0]   nb_d;
	logic               ovf_d;

	// Advance everything when the serializer is empty or hands off its final byte
	assign ser_last     = (ser_k_q == '0);
	assign adv          = !ser_vld_q || (digits.ready && ser_last);
	assign number.ready = adv;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DAB_STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= number.valid;
			for (int i = 1; i < DAB_STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			vld_s6 <= vld_s[DAB_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dab_s[0] <= dab_stage('{bin: number.value, bcd: '0});
			for (int i = 1; i < DAB_STAGES; i++) begin
				dab_s[i] <= dab_stage(dab_s[i-1]);
			end
		end
	end

	// Count the digits, then the bytes: ceil(count/2), at least one
	always_comb begin
		cnt_d = count_digits(dab_s[DAB_STAGES-1].bcd);
		nb_d  = POS_W'(({1'b0, cnt_d} + 5'd1) >> 1);
		if (cnt_d == '0) begin
			nb_d = POS_W'(1);
		end
		ovf_d = ({1'b0, cnt_d} > 5'(MAX_DIGITS)) || ({1'b0, nb_d} > 4'(FIELD_BYTES));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bcd_s6 <= dab_s[DAB_STAGES-1].bcd;
			cnt_s6 <= cnt_d;
			top_s6 <= nb_d - POS_W'(1);
			ovf_s6 <= ovf_d;
		end
	end

	// Serializer: load on advance, else step down one byte per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			ser_k_q   <= '0;
		end else if (adv) begin
			ser_vld_q <= vld_s6;
			ser_k_q   <= ovf_s6 ? '0 : top_s6;
		end else if (digits.ready) begin
			ser_k_q <= ser_k_q - POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ser_bytes_q <= {{(8*BYTE_SLOTS-BCD_W){1'b0}}, bcd_s6};
			ser_cnt_q   <= cnt_s6;
			ser_top_q   <= top_s6;
			ser_ovf_q   <= ovf_s6;
		end
	end

	// Odd count: the top byte holds only one digit; fill its high nibble
	assign ser_pad = ser_cnt_q[0] && (ser_k_q == ser_top_q);

	always_comb begin
		digits.valid    = ser_vld_q;
		digits.overflow = ser_ovf_q;
		digits.last     = ser_last;
		if (ser_ovf_q) begin
			digits.byte_value    = '0;
			digits.byte_position = '0;
			digits.digit_count   = '0;
		end else begin
			digits.byte_value    = ser_bytes_q[ser_k_q] | (ser_pad ? PAD_BYTE : 8'h00);
			digits.byte_position = POS_W'(FIELD_BYTES - 1) - ser_k_q;
			digits.digit_count   = ser_cnt_q;
		end
	end

`ifndef SYNTHESIS
	// Byte index stays inside the packed field of the held item
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q && !ser_ovf_q |-> ser_k_q <= ser_top_q)
		else $error("serializer byte index beyond top byte");

	// No new item enters while the serializer still owes bytes
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q && !(digits.ready && ser_last) |-> !number.ready)
		else $error("input accepted while serializer busy");

	// A stall freezes the pipeline tail
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s6) && $stable(ser_cnt_q))
		else $error("pipeline moved during stall");

	// An overflow result is a single transaction
	a_ovf_single: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q && ser_ovf_q |-> ser_last)
		else $error("overflow result is not final");
`endif

endmodule
